FILE: src/bevad_pkg.sv
`default_nettype none
package bevad_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_BLOCK   = 8192;
   localparam int MIN_RUN_RST = 10;
   localparam int THR_W       = 15;
   localparam int MIN_RUN_W   = 8;
   localparam int RUN_W       = 16;
   localparam int TOTAL_W     = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;

   // square of a full-scale sample fits in one bit less than twice the sample width
   localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
   localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W   = SQ_W + CNT_W - 1;
   localparam int THR2_W  = 2 * THR_W;
   localparam int LIM_W   = THR2_W + CNT_W;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_THR  = 2'd0,
      CSR_HIGH_THR = 2'd1,
      CSR_MIN_RUN  = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_CLEAR  = 1'b1
   } kind_type;

   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          block_end;
   } req_type;

   typedef struct packed {
      logic               speech_detected;
      logic               in_band;
      logic [TOTAL_W-1:0] in_band_blocks;
      logic [RUN_W-1:0]   run_length;
   } rsp_type;

   typedef struct packed {
      logic            kind;
      logic            block_end;
      logic [SQ_W-1:0] sq;
   } q_entry_type;

endpackage
`default_nettype wire

FILE: src/block_energy_voice_activity.sv
// Path from the item that ends a block to its result: front square register, queue,
//   accumulate, threshold square, two limit multiplies, decision.
// Throughput: one sample item per cycle while not stalled; a block end holds the back end
//   while the limits are multiplied out, and the 4-entry queue absorbs samples meanwhile.
// Reset: synchronous, active high; clears queue, accumulators, counters and flag, and
//   restores thresholds to zero and min_run to 10.
`default_nettype none
module block_energy_voice_activity (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  bevad_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output bevad_pkg::rsp_type              rsp_data,
   input  wire                             csr_we,
   input  wire [bevad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [bevad_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bevad_pkg::*;

   logic        fq_valid, fq_ready;
   q_entry_type fq_data;
   logic        qb_valid, qb_ready;
   q_entry_type qb_data;

   bevad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   bevad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   bevad_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (qb_valid),
      .q_ready   (qb_ready),
      .q_data    (qb_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: src/bevad_front.sv
`default_nettype none
module bevad_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  bevad_pkg::req_type   req_data,
   output logic                 q_valid,
   input  wire                  q_ready,
   output bevad_pkg::q_entry_type q_data
);
   import bevad_pkg::*;

   logic                stage_valid_ff, stage_valid_in;
   q_entry_type         stage_ff, stage_in;
   logic signed [2*SAMPLE_BITS-1:0] prod;

   assign prod      = (2*SAMPLE_BITS)'(req_data.sample) * (2*SAMPLE_BITS)'(req_data.sample);
   assign req_ready = !stage_valid_ff || q_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      if (req_ready) begin
         stage_valid_in     = req_valid;
         stage_in.kind      = req_data.kind;
         stage_in.block_end = req_data.block_end;
         // product of a value with itself is never negative
         stage_in.sq        = prod[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

   assign q_valid = stage_valid_ff;
   assign q_data  = stage_ff;

endmodule
`default_nettype wire

FILE: src/bevad_queue.sv
`default_nettype none
module bevad_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  bevad_pkg::q_entry_type in_data,
   output logic                   out_valid,
   input  wire                    out_ready,
   output bevad_pkg::q_entry_type out_data
);
   import bevad_pkg::*;

   q_entry_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = count_ff != Q_CNT_W'(Q_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

FILE: src/bevad_back.sv
`default_nettype none
module bevad_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            q_valid,
   output logic                           q_ready,
   input  bevad_pkg::q_entry_type         q_data,
   input  wire                            csr_we,
   input  wire [bevad_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [bevad_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output bevad_pkg::rsp_type             rsp_data
);
   import bevad_pkg::*;

   typedef enum logic [4:0] {
      S_RUN = 5'b00001,
      S_SQ  = 5'b00010,
      S_MLO = 5'b00100,
      S_MHI = 5'b01000,
      S_DEC = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic                 flag_ff, flag_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [THR_W-1:0]     low_ff, low_in;
   logic [THR_W-1:0]     high_ff, high_in;
   logic [MIN_RUN_W-1:0] min_run_ff, min_run_in;
   logic [THR2_W-1:0]    lo2_ff, lo2_in;
   logic [THR2_W-1:0]    hi2_ff, hi2_in;
   logic [LIM_W-1:0]     lim_lo_ff, lim_lo_in;
   logic [LIM_W-1:0]     lim_hi_ff, lim_hi_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 band;
   logic [RUN_W-1:0]     run_next;
   logic                 out_free;
   logic [LIM_W-1:0]     sum_ext;

   assign q_ready  = state_ff == S_RUN;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sum_ext  = LIM_W'(sum_ff);
   assign band     = (low_ff != '0) && (sum_ext > lim_lo_ff)
                     && ((high_ff == '0) || (sum_ext < lim_hi_ff));
   assign run_next = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      run_in       = run_ff;
      flag_in      = flag_ff;
      total_in     = total_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      min_run_in   = min_run_ff;
      lo2_in       = lo2_ff;
      hi2_in       = hi2_ff;
      lim_lo_in    = lim_lo_ff;
      lim_hi_in    = lim_hi_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_RUN: begin
            if (q_valid) begin
               if (q_data.kind == KIND_CLEAR) begin
                  flag_in = 1'b0;
                  run_in  = '0;
               end else begin
                  // hold the sum once the block is full; the end mark still ends the block
                  if (cnt_ff < CNT_W'(MAX_BLOCK)) begin
                     sum_in = sum_ff + SUM_W'(q_data.sq);
                     cnt_in = cnt_ff + 1'b1;
                  end
                  if (q_data.block_end) begin
                     state_in = S_SQ;
                  end
               end
            end
         end
         S_SQ: begin
            lo2_in   = THR2_W'({{THR_W{1'b0}}, low_ff} * {{THR_W{1'b0}}, low_ff});
            hi2_in   = THR2_W'({{THR_W{1'b0}}, high_ff} * {{THR_W{1'b0}}, high_ff});
            state_in = S_MLO;
         end
         S_MLO: begin
            lim_lo_in = LIM_W'({{CNT_W{1'b0}}, lo2_ff} * {{THR2_W{1'b0}}, cnt_ff});
            state_in  = S_MHI;
         end
         S_MHI: begin
            lim_hi_in = LIM_W'({{CNT_W{1'b0}}, hi2_ff} * {{THR2_W{1'b0}}, cnt_ff});
            state_in  = S_DEC;
         end
         S_DEC: begin
            // wait for the output register to drain
            if (out_free) begin
               rsp_in.speech_detected = flag_ff;
               rsp_in.in_band         = band;
               rsp_in.in_band_blocks  = total_ff;
               rsp_in.run_length      = run_ff;
               if (low_ff != '0) begin
                  if (band) begin
                     total_in = total_ff + 1'b1;
                     run_in   = run_next;
                     rsp_in.in_band_blocks = total_ff + 1'b1;
                     rsp_in.run_length     = run_next;
                     if (run_next >= RUN_W'(min_run_ff)) begin
                        flag_in = 1'b1;
                        rsp_in.speech_detected = 1'b1;
                     end
                  end else begin
                     run_in = '0;
                     rsp_in.run_length = '0;
                  end
               end
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               cnt_in       = '0;
               state_in     = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_LOW_THR: begin
               low_in  = csr_wdata[THR_W-1:0];
               flag_in = 1'b0;
            end
            CSR_HIGH_THR: begin
               high_in = csr_wdata[THR_W-1:0];
               flag_in = 1'b0;
            end
            CSR_MIN_RUN: begin
               min_run_in = csr_wdata[MIN_RUN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         run_ff       <= '0;
         flag_ff      <= 1'b0;
         total_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         min_run_ff   <= MIN_RUN_W'(MIN_RUN_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         flag_ff      <= flag_in;
         total_ff     <= total_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         min_run_ff   <= min_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo2_ff    <= lo2_in;
      hi2_ff    <= hi2_in;
      lim_lo_ff <= lim_lo_in;
      lim_hi_ff <= lim_hi_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: src/bevad_checker.sv
`default_nettype none
module bevad_checker (
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input bevad_pkg::rsp_type rsp_data
);
   import bevad_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // an in-band block always leaves a non-empty run
   a_band_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_band |-> rsp_data.run_length != '0)
      else $error("in-band block with empty run");

   // an in-band result never shows an empty total together with an empty run
   a_band_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_band |-> rsp_data.in_band_blocks != '0
         || rsp_data.run_length != '0)
      else $error("in-band total inconsistent");

endmodule

bind block_energy_voice_activity bevad_checker u_bevad_checker (.*);
`default_nettype wire
